[hdl/apfc_pkg.sv]
package apfc_pkg;

	// output formats, codes five to seven fold onto rgb
	typedef enum logic [2:0] {
		MODE_RGB        = 3'd0,
		MODE_RGBA_UNPREM = 3'd1,
		MODE_RGBA_PREM  = 3'd2,
		MODE_GRAY       = 3'd3,
		MODE_MONO       = 3'd4
	} mode_t;

	// source of an emitted byte
	typedef enum logic [2:0] {
		SEL_R,
		SEL_G,
		SEL_B,
		SEL_A,
		SEL_GRAY,
		SEL_MONO,
		SEL_QUOT
	} sel_t;

	// register index of the configuration port
	localparam logic REG_OUTPUT_MODE = 1'b0;

	// luma weights, sum of the three is 65536
	localparam logic [15:0] GRAY_KR  = 16'd19661;
	localparam logic [15:0] GRAY_KG  = 16'd38666;
	localparam logic [15:0] GRAY_KB  = 16'd7209;
	localparam logic [23:0] GRAY_RND = 24'd32829;
	localparam logic [7:0]  MONO_THRESH = 8'd127;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mac_en;
		logic [1:0] ch;
		logic       div_start;
		logic       div_step;
		logic       emit;
		sel_t       sel;
		logic       last;
		logic       mono_upd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		mode_t mode_new;
		logic  mono_fire;
		logic  out_free;
	} sts_t;

	// fold unused codes onto rgb
	function automatic mode_t to_mode(input logic [2:0] raw);
		mode_t m;
		case (raw)
			3'd1: m = MODE_RGBA_UNPREM;
			3'd2: m = MODE_RGBA_PREM;
			3'd3: m = MODE_GRAY;
			3'd4: m = MODE_MONO;
			default: m = MODE_RGB;
		endcase
		return m;
	endfunction

endpackage

[hdl/apfc_ifs.sv]
interface apfc_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] argb_pixel;
	logic        row_end;

	modport source (output valid, argb_pixel, row_end, input ready);
	modport sink (input valid, argb_pixel, row_end, output ready);
endinterface

interface apfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       pixel_done;
	logic       row_done;

	modport source (output valid, out_byte, pixel_done, row_done, input ready);
	modport sink (input valid, out_byte, pixel_done, row_done, output ready);
endinterface

[hdl/apfc_ctrl.sv]
module apfc_ctrl
	import apfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DSTART,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	sel_t       sel_c;

	// byte order per format
	always_comb begin
		last_idx = 2'd2;
		sel_c = SEL_R;
		case (sts.mode)
			MODE_GRAY: begin
				last_idx = 2'd0;
				sel_c = SEL_GRAY;
			end
			MODE_RGBA_UNPREM: begin
				last_idx = 2'd3;
				sel_c = (idx_q == 2'd3) ? SEL_A : SEL_QUOT;
			end
			default: begin
				if (sts.mode == MODE_RGBA_PREM)
					last_idx = 2'd3;
				case (idx_q)
					2'd0: sel_c = SEL_R;
					2'd1: sel_c = SEL_G;
					2'd2: sel_c = SEL_B;
					default: sel_c = SEL_A;
				endcase
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.sel = SEL_R;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_MAC: begin
				cmd.mac_en = 1'b1;
				cmd.ch = cnt_q[1:0];
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				cmd.ch = idx_q;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_EMIT: begin
				if (sts.mode == MODE_MONO) begin
					cmd.mono_upd = !sts.mono_fire || sts.out_free;
					cmd.emit = sts.mono_fire && sts.out_free;
					cmd.sel = SEL_MONO;
					cmd.last = 1'b1;
				end else begin
					cmd.emit = sts.out_free;
					cmd.sel = sel_c;
					cmd.last = (idx_q == last_idx);
				end
			end
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						idx_q <= '0;
						if (sts.mode_new == MODE_GRAY || sts.mode_new == MODE_MONO)
							state_q <= ST_MAC;
						else if (sts.mode_new == MODE_RGBA_UNPREM)
							state_q <= ST_DSTART;
						else
							state_q <= ST_EMIT;
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd2)
						state_q <= ST_EMIT;
				end
				ST_DSTART: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.mode == MODE_MONO) begin
						if (cmd.mono_upd)
							state_q <= ST_IDLE;
					end else if (sts.out_free) begin
						if (cmd.last)
							state_q <= ST_IDLE;
						else begin
							idx_q <= idx_q + 2'd1;
							if (sts.mode == MODE_RGBA_UNPREM && idx_q != 2'd2)
								state_q <= ST_DSTART;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// an accepted item always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && in_valid |=> state_q != ST_IDLE)
		else $error("accepted item left controller idle");

	// a byte is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit into occupied output register");

	// division always completes its eight steps before a byte
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q != 3'd7) |=> state_q == ST_DIV)
		else $error("division cut short");
`endif

endmodule

[hdl/apfc_dp.sv]
module apfc_dp
	import apfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [2:0]  cfg_mode,
	input  logic [31:0] in_pixel,
	input  logic        in_row_end,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        out_pixel_done,
	output logic        out_row_done
);

	logic [7:0]  a_q, r_q, g_q, b_q;
	logic        rend_q;
	mode_t       mode_q;
	mode_t       mode_new;
	logic [23:0] acc_q;
	logic [7:0]  mac_chan;
	logic [15:0] mac_coef;
	logic [23:0] mac_prod;
	logic [7:0]  gray;
	logic [2:0]  pos_q;
	logic [7:0]  macc_q;
	logic [7:0]  mono_byte;
	logic        mono_fire;
	logic [7:0]  div_chan;
	logic [15:0] dividend;
	logic [7:0]  rem_q;
	logic [7:0]  dvd_q;
	logic [7:0]  quot_q;
	logic        fix_q;
	logic [7:0]  fix_val_q;
	logic [8:0]  rem_sh;
	logic [8:0]  rem_sub;
	logic        div_ge;
	logic [7:0]  quot;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        pd_q, rd_q;
	logic [7:0]  byte_c;

	assign mode_new = to_mode(cfg_mode);

	// pixel capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= in_pixel[31:24];
			r_q <= in_pixel[23:16];
			g_q <= in_pixel[15:8];
			b_q <= in_pixel[7:0];
			rend_q <= in_row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_RGB;
		else if (cmd.load)
			mode_q <= mode_new;
	end

	// gray weighted sum, one channel a cycle
	always_comb begin
		case (cmd.ch)
			2'd0: begin
				mac_chan = r_q;
				mac_coef = GRAY_KR;
			end
			2'd1: begin
				mac_chan = g_q;
				mac_coef = GRAY_KG;
			end
			default: begin
				mac_chan = b_q;
				mac_coef = GRAY_KB;
			end
		endcase
		mac_prod = {16'h0000, mac_chan} * {8'h00, mac_coef};
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			acc_q <= GRAY_RND;
		else if (cmd.mac_en)
			acc_q <= acc_q + mac_prod;
	end

	assign gray = acc_q[23:16];

	// mono packing, msb first
	assign mono_byte = ((pos_q == 3'd7) ? 8'h00 : macc_q)
		| ((gray > MONO_THRESH) ? (8'h01 << pos_q) : 8'h00);
	assign mono_fire = (pos_q == 3'd0) || rend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd7;
			macc_q <= '0;
		end else if (cmd.load && in_row_end && mode_new != MODE_MONO) begin
			pos_q <= 3'd7;
			macc_q <= '0;
		end else if (cmd.mono_upd) begin
			if (mono_fire) begin
				pos_q <= 3'd7;
				macc_q <= '0;
			end else begin
				pos_q <= pos_q - 3'd1;
				macc_q <= mono_byte;
			end
		end
	end

	// unpremultiply: (c*255 + a/2) / a, restoring, one quotient bit a step
	always_comb begin
		case (cmd.ch)
			2'd0: div_chan = r_q;
			2'd1: div_chan = g_q;
			default: div_chan = b_q;
		endcase
		dividend = ({div_chan, 8'h00} - {8'h00, div_chan}) + {9'h000, a_q[7:1]};
		rem_sh = {rem_q, dvd_q[7]};
		rem_sub = rem_sh - {1'b0, a_q};
		div_ge = (rem_sh >= {1'b0, a_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quot_q <= '0;
			rem_q <= dividend[15:8];
			dvd_q <= dividend[7:0];
			if (a_q == 8'h00) begin
				fix_q <= 1'b1;
				fix_val_q <= 8'h00;
			end else if (div_chan >= a_q) begin
				fix_q <= 1'b1;
				fix_val_q <= 8'hff;
			end else begin
				fix_q <= 1'b0;
				fix_val_q <= 8'h00;
			end
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? rem_sub[7:0] : rem_sh[7:0];
			dvd_q <= {dvd_q[6:0], 1'b0};
			quot_q <= {quot_q[6:0], div_ge};
		end
	end

	assign quot = fix_q ? fix_val_q : quot_q;

	// byte select
	always_comb begin
		case (cmd.sel)
			SEL_R:    byte_c = r_q;
			SEL_G:    byte_c = g_q;
			SEL_B:    byte_c = b_q;
			SEL_A:    byte_c = a_q;
			SEL_GRAY: byte_c = gray;
			SEL_MONO: byte_c = mono_byte;
			SEL_QUOT: byte_c = quot;
			default:  byte_c = r_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= byte_c;
			pd_q <= cmd.last;
			rd_q <= cmd.last && rend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = byte_q;
	assign out_pixel_done = pd_q;
	assign out_row_done = rd_q;

	assign sts.mode = mode_q;
	assign sts.mode_new = mode_new;
	assign sts.mono_fire = mono_fire;
	assign sts.out_free = !out_valid_q || out_ready;

`ifndef ASSERT_OFF
	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && !fix_q |-> rem_q < a_q)
		else $error("divider remainder out of range");

	// a finished mono byte restarts the packer
	a_mono_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mono_upd && mono_fire |=> (pos_q == 3'd7) && (macc_q == 8'h00))
		else $error("mono packer not restarted");
`endif

endmodule

[hdl/argb_pixel_row_format_converter.sv]
// pixel to byte stream converter, one item in work at a time
// per item: rgb and rgba premultiplied emit bytes straight from the pixel, gray and mono first run the
// weighted sum, rgba unpremultiplied runs the eight-step divider once per colour; an output stall holds the item
// rgb goes from accept straight to emitting its first byte, one output register holds it
// reset (arst_n low, asynchronous): mode rgb, mono packer empty at bit seven, output empty
module argb_pixel_row_format_converter
	import apfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	apfc_pix_if.sink    pixel,
	apfc_byte_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] output_mode_q;
	logic       cfg_wr;
	cmd_t       cmd;
	sts_t       sts;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			output_mode_q <= 3'd0;
		else if (cfg_wr)
			output_mode_q <= pwdata[2:0];
	end

	assign prdata = (paddr[2] == REG_OUTPUT_MODE) ? {29'h0, output_mode_q} : 32'h0;

	// sequencer
	apfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	apfc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_mode       (output_mode_q),
		.in_pixel       (pixel.argb_pixel),
		.in_row_end     (pixel.row_end),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_byte       (result.out_byte),
		.out_pixel_done (result.pixel_done),
		.out_row_done   (result.row_done)
	);

endmodule

[sim/tb_argb_pixel_row_format_converter.sv]
module tb_argb_pixel_row_format_converter;
	import apfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// one expected output byte with its marks
	typedef struct packed {
		logic [7:0] out_byte;
		logic       pixel_done;
		logic       row_done;
	} byte_due_t;

	// predicts the byte stream of the converter and checks what comes out
	class row_stream_scoreboard;
		logic [2:0] mode_raw;
		logic [7:0] mono_bits;
		logic [2:0] mono_slot;
		byte_due_t  bytes_due[$];
		int         errors;

		function new();
			mode_raw  = MODE_RGB;
			mono_bits = 8'd0;
			mono_slot = 3'd7;
			errors    = 0;
		endfunction

		function void set_mode(logic [2:0] raw);
			mode_raw = raw;
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction

		function logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned sum;
			sum = r * GRAY_KR + g * GRAY_KG + b * GRAY_KB + GRAY_RND;
			return sum[23:16];
		endfunction

		// divide one colour by alpha with rounding, saturate at 255, zero alpha gives zero
		function logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
			int unsigned q;
			if (a == 8'd0) begin
				return 8'd0;
			end
			q = (c * 255 + a / 2) / a;
			return (q > 255) ? 8'd255 : q[7:0];
		endfunction

		function void push(logic [7:0] b, logic pd, logic rd);
			byte_due_t e;
			e.out_byte   = b;
			e.pixel_done = pd;
			e.row_done   = rd;
			bytes_due.push_back(e);
		endfunction

		// an accepted pixel item
		function void note_pixel(logic [31:0] argb, logic row_end);
			logic [7:0] a, r, g, b, gy;
			a  = argb[31:24];
			r  = argb[23:16];
			g  = argb[15:8];
			b  = argb[7:0];
			gy = luma(r, g, b);
			// mono packer, byte out on the last slot or at row end
			if (mode_raw == MODE_MONO) begin
				if (mono_slot == 3'd7) begin
					mono_bits = 8'd0;
				end
				if (gy > MONO_THRESH) begin
					mono_bits[mono_slot] = 1'b1;
				end
				if (mono_slot == 3'd0 || row_end) begin
					push(mono_bits, 1'b1, row_end);
					mono_bits = 8'd0;
					mono_slot = 3'd7;
				end else begin
					mono_slot = mono_slot - 3'd1;
				end
				return;
			end
			// row end in any other format clears the packer
			if (row_end) begin
				mono_bits = 8'd0;
				mono_slot = 3'd7;
			end
			case (mode_raw)
				MODE_GRAY: begin
					push(gy, 1'b1, row_end);
				end
				MODE_RGBA_UNPREM: begin
					push(unpremultiply(r, a), 1'b0, 1'b0);
					push(unpremultiply(g, a), 1'b0, 1'b0);
					push(unpremultiply(b, a), 1'b0, 1'b0);
					push(a, 1'b1, row_end);
				end
				MODE_RGBA_PREM: begin
					push(r, 1'b0, 1'b0);
					push(g, 1'b0, 1'b0);
					push(b, 1'b0, 1'b0);
					push(a, 1'b1, row_end);
				end
				default: begin
					push(r, 1'b0, 1'b0);
					push(g, 1'b0, 1'b0);
					push(b, 1'b1, row_end);
				end
			endcase
		endfunction

		// an accepted output byte against the oldest expectation
		function void check_byte(logic [7:0] b, logic pd, logic rd);
			byte_due_t e;
			if (bytes_due.size() == 0) begin
				$error("unexpected out_byte %0h pixel_done %0b row_done %0b", b, pd, rd);
				errors++;
				return;
			end
			e = bytes_due.pop_front();
			if (b !== e.out_byte) begin
				$error("out_byte expected %0h actual %0h", e.out_byte, b);
				errors++;
			end
			if (pd !== e.pixel_done) begin
				$error("pixel_done expected %0b actual %0b", e.pixel_done, pd);
				errors++;
			end
			if (rd !== e.row_done) begin
				$error("row_done expected %0b actual %0b", e.row_done, rd);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	apfc_pix_if  pix_if();
	apfc_byte_if byte_if();

	row_stream_scoreboard sb;
	bit no_idle;
	int rx_hold;
	int left_to_send;

	argb_pixel_row_format_converter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_if),
		.result  (byte_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#3ms;
		$display("argb_pixel_row_format_converter verification failed");
		$finish;
	end

	// write the mode register through the bus, setup then access
	task automatic write_mode(logic [2:0] raw);
		logic [31:0] word;
		word = $urandom;
		word[2:0] = raw;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = 3'(REG_OUTPUT_MODE) << 2;
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_mode(raw);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// wait until every byte is out, then let a silent mono item finish
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// offer one pixel item and wait for its acceptance
	task automatic send_pixel(logic [31:0] argb, logic row_end);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			pix_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.valid      = 1'b1;
		pix_if.argb_pixel = argb;
		pix_if.row_end    = row_end;
		do @(posedge clk); while (!pix_if.ready);
		sb.note_pixel(argb, row_end);
		@(negedge clk);
	endtask

	task automatic end_burst();
		pix_if.valid = 1'b0;
	endtask

	// random pixel drawn from a few shapes
	function automatic logic [31:0] pick_pixel();
		logic [31:0] p;
		logic [7:0]  a;
		p = $urandom;
		a = p[31:24];
		case ($urandom_range(0, 5))
			0: p[31:24] = 8'hff;
			1: begin
				p[23:16] = (a == 0) ? 8'd0 : 8'($urandom_range(0, a));
				p[15:8]  = (a == 0) ? 8'd0 : 8'($urandom_range(0, a));
				p[7:0]   = (a == 0) ? 8'd0 : 8'($urandom_range(0, a));
			end
			2: p[31:24] = 8'd0;
			3: begin
				p[23:16] = 8'($urandom_range(120, 135));
				p[15:8]  = 8'($urandom_range(120, 135));
				p[7:0]   = 8'($urandom_range(120, 135));
			end
			default: ;
		endcase
		return p;
	endfunction

	// receiver: random stall per byte item, long hold-off on request
	initial begin
		int gap;
		byte_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				byte_if.ready = 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				byte_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			byte_if.ready = 1'b1;
			do @(posedge clk); while (!byte_if.valid);
			sb.check_byte(byte_if.out_byte, byte_if.pixel_done, byte_if.row_done);
		end
	end

	// main sequence
	initial begin
		int n;
		int phase;
		logic [2:0] m;
		sb = new();
		no_idle = 1'b0;
		rx_hold = 0;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = 3'd0;
		pwdata  = 32'd0;
		pix_if.valid      = 1'b0;
		pix_if.argb_pixel = 32'd0;
		pix_if.row_end    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// rgb from reset, extremes
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hffff_ffff, 1'b1);
		end_burst();
		settle();

		// unpremultiplied: zero alpha, colour above alpha, alpha one
		write_mode(MODE_RGBA_UNPREM);
		send_pixel(32'h0012_3456, 1'b0);
		send_pixel(32'h40ff_8020, 1'b0);
		send_pixel(32'h0101_0001, 1'b0);
		send_pixel(32'hff80_7fff, 1'b1);
		end_burst();
		settle();

		write_mode(MODE_RGBA_PREM);
		send_pixel(32'ha512_3456, 1'b1);
		end_burst();
		settle();

		// gray on both sides of the threshold
		write_mode(MODE_GRAY);
		send_pixel(32'h0080_8080, 1'b0);
		send_pixel(32'h007f_7f7f, 1'b1);
		end_burst();
		settle();

		// mono: one full byte, then a partial byte at row end
		write_mode(MODE_MONO);
		for (int i = 0; i < 8; i++) begin
			send_pixel((i % 3 == 0) ? 32'hffff_ffff : 32'h0010_1010, 1'b0);
		end
		send_pixel(32'hff_ffffff, 1'b0);
		send_pixel(32'h00_ffffff, 1'b1);
		// mono byte interrupted by gray without row end keeps its bits
		send_pixel(32'h00ff_ffff, 1'b0);
		end_burst();
		settle();
		write_mode(MODE_GRAY);
		send_pixel(32'h0000_0000, 1'b0);
		end_burst();
		settle();
		write_mode(MODE_MONO);
		send_pixel(32'h00ff_ffff, 1'b1);
		// a row end in rgb clears a partial byte
		send_pixel(32'h00ff_ffff, 1'b0);
		end_burst();
		settle();
		write_mode(3'd5);
		send_pixel(32'h1234_5678, 1'b1);
		end_burst();
		settle();
		write_mode(MODE_MONO);
		send_pixel(32'h0000_0000, 1'b1);
		end_burst();
		settle();
		write_mode(3'd6);
		send_pixel(32'h8765_4321, 1'b0);
		end_burst();
		settle();
		write_mode(3'd7);
		send_pixel(32'hfedc_ba98, 1'b1);
		end_burst();
		settle();

		// random phases, each in its own format
		left_to_send = 430;
		phase = 0;
		while (left_to_send > 0) begin
			m = (phase == 3) ? MODE_RGBA_PREM : 3'($urandom_range(0, 7));
			if (phase != 3 && $urandom_range(0, 2) == 0) begin
				m = MODE_MONO;
			end
			write_mode(m);
			no_idle = ($urandom_range(0, 3) == 0);
			n = $urandom_range(4, 30);
			if (n > left_to_send) begin
				n = left_to_send;
			end
			// receiver holds off while the sender keeps offering
			if (phase == 3) begin
				rx_hold = 300;
			end
			for (int i = 0; i < n; i++) begin
				send_pixel(pick_pixel(), ($urandom_range(0, 5) == 0));
			end
			end_burst();
			left_to_send -= n;
			phase++;
			settle();
		end

		no_idle = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("argb_pixel_row_format_converter verification clean");
		end else begin
			$display("argb_pixel_row_format_converter verification failed");
		end
		$finish;
	end

endmodule
